// ===== rtl/core/tty_pair_fifo_crlf_top_defines.svh =====
// Assertion macros for the pseudo-terminal ring pair.
`ifndef TTY_PAIR_FIFO_CRLF_TOP_DEFINES_SVH
`define TTY_PAIR_FIFO_CRLF_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TPFC_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tpfc assertion failed");
`define TPFC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tpfc assertion failed");
`else
`define TPFC_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define TPFC_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ===== rtl/core/tpfc_pkg.sv =====
// Shared constants, types and a helper function for the pseudo-terminal ring pair.
package tpfc_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;

  localparam byte_t CHAR_CR = 8'h0D;
  localparam byte_t CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    OP_MASTER_PUSH = 3'd0,
    OP_SLAVE_PUSH  = 3'd1,
    OP_MASTER_POP  = 3'd2,
    OP_SLAVE_POP   = 3'd3,
    OP_FLUSH       = 3'd4
  } op_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LF,
    S_RESP
  } state_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== rtl/core/tpfc_ram.sv =====
// One ring store: a single-port-write, single-port-read byte memory with registered read.
module tpfc_ram (
  input  logic            clk,
  input  logic            wr_en,
  input  tpfc_pkg::ptr_t  wr_addr,
  input  tpfc_pkg::byte_t wr_data,
  input  logic            rd_en,
  input  tpfc_pkg::ptr_t  rd_addr,
  output tpfc_pkg::byte_t rd_data
);

  tpfc_pkg::byte_t mem [tpfc_pkg::RING_DEPTH];
  tpfc_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tty_pair_fifo_crlf_top.sv =====
// Top level of the pseudo-terminal ring pair with slave line feed translation.
//
// The input channel (in_valid/in_ready) carries one item: an op code and a byte.
// The result channel (out_valid/out_ready) returns exactly one item per input:
// the accepted flag, the popped byte and the four readable/writable flags.
// The cfg_wr_en/cfg_wr_data port writes crlf_enable.
// An accepted item passes through the execute state and then the response
// state, and a slave line feed that is stored as CR then LF also passes through
// the line-feed state between them, since each ring memory has one write port
// and the two bytes go in on successive cycles. A pop reads the memory in the
// execute cycle and the registered data feeds the result. One item is in work
// at a time; the next is accepted the cycle after the result is loaded into the
// output register, and a new item can enter while the previous result still
// waits to be taken.
// Synchronous reset empties both rings, sets crlf_enable and drops out_valid.
// The memories need no clearing pass. When the receiver stalls, the result
// stays in the output register and the block stops after finishing the next item.
`include "tty_pair_fifo_crlf_top_defines.svh"
module tty_pair_fifo_crlf_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic [7:0] out_byte_out,
  output logic       out_master_readable,
  output logic       out_master_writable,
  output logic       out_slave_readable,
  output logic       out_slave_writable,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  tpfc_pkg::state_t state_r, state_nxt;
  logic [2:0]       op_r;
  tpfc_pkg::byte_t  byte_r;
  logic             ok_r, ok_nxt;
  logic             crlf_r;

  tpfc_pkg::ptr_t dw_r, dw_nxt, dr_r, dr_nxt;
  tpfc_pkg::ptr_t uw_r, uw_nxt, ur_r, ur_nxt;

  logic            down_we, up_we, down_re, up_re;
  tpfc_pkg::byte_t up_wdata;
  tpfc_pkg::byte_t down_rdata, up_rdata;

  logic            out_valid_r;
  logic            out_accepted_r;
  tpfc_pkg::byte_t out_byte_r;
  logic            out_mr_r, out_mw_r, out_sr_r, out_sw_r;

  logic in_fire, out_free;
  logic down_has_slot, up_has_slot, up_has_two;
  tpfc_pkg::byte_t got;

  assign in_ready = (state_r == tpfc_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign down_has_slot = (tpfc_pkg::ptr_inc(dw_r) != dr_r);
  assign up_has_slot   = (tpfc_pkg::ptr_inc(uw_r) != ur_r);
  assign up_has_two    = up_has_slot &&
                         (tpfc_pkg::ptr_inc(tpfc_pkg::ptr_inc(uw_r)) != ur_r);

  tpfc_ram u_down_ram (
    .clk     (clk),
    .wr_en   (down_we),
    .wr_addr (dw_r),
    .wr_data (byte_r),
    .rd_en   (down_re),
    .rd_addr (dr_r),
    .rd_data (down_rdata)
  );

  tpfc_ram u_up_ram (
    .clk     (clk),
    .wr_en   (up_we),
    .wr_addr (uw_r),
    .wr_data (up_wdata),
    .rd_en   (up_re),
    .rd_addr (ur_r),
    .rd_data (up_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpfc_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = tpfc_pkg::S_EXEC;
        end
      end
      tpfc_pkg::S_EXEC: begin
        if (tpfc_pkg::op_e_t'(op_r) == tpfc_pkg::OP_SLAVE_PUSH && crlf_r &&
            byte_r == tpfc_pkg::CHAR_LF && up_has_two) begin
          state_nxt = tpfc_pkg::S_LF;
        end else begin
          state_nxt = tpfc_pkg::S_RESP;
        end
      end
      tpfc_pkg::S_LF: begin
        state_nxt = tpfc_pkg::S_RESP;
      end
      tpfc_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = tpfc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tpfc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    down_we  = 1'b0;
    up_we    = 1'b0;
    down_re  = 1'b0;
    up_re    = 1'b0;
    up_wdata = byte_r;
    ok_nxt   = ok_r;
    dw_nxt   = dw_r;
    dr_nxt   = dr_r;
    uw_nxt   = uw_r;
    ur_nxt   = ur_r;
    unique case (state_r)
      tpfc_pkg::S_EXEC: begin
        ok_nxt = 1'b0;
        unique case (tpfc_pkg::op_e_t'(op_r))
          tpfc_pkg::OP_MASTER_PUSH: begin
            if (down_has_slot) begin
              down_we = 1'b1;
              dw_nxt  = tpfc_pkg::ptr_inc(dw_r);
              ok_nxt  = 1'b1;
            end
          end
          tpfc_pkg::OP_SLAVE_PUSH: begin
            if (crlf_r && byte_r == tpfc_pkg::CHAR_LF) begin
              if (up_has_two) begin
                up_we    = 1'b1;
                up_wdata = tpfc_pkg::CHAR_CR;
                uw_nxt   = tpfc_pkg::ptr_inc(uw_r);
                ok_nxt   = 1'b1;
              end
            end else if (up_has_slot) begin
              up_we  = 1'b1;
              uw_nxt = tpfc_pkg::ptr_inc(uw_r);
              ok_nxt = 1'b1;
            end
          end
          tpfc_pkg::OP_MASTER_POP: begin
            if (uw_r != ur_r) begin
              up_re  = 1'b1;
              ur_nxt = tpfc_pkg::ptr_inc(ur_r);
              ok_nxt = 1'b1;
            end
          end
          tpfc_pkg::OP_SLAVE_POP: begin
            if (dw_r != dr_r) begin
              down_re = 1'b1;
              dr_nxt  = tpfc_pkg::ptr_inc(dr_r);
              ok_nxt  = 1'b1;
            end
          end
          tpfc_pkg::OP_FLUSH: begin
            dw_nxt = '0;
            dr_nxt = '0;
            uw_nxt = '0;
            ur_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      tpfc_pkg::S_LF: begin
        up_we    = 1'b1;
        up_wdata = tpfc_pkg::CHAR_LF;
        uw_nxt   = tpfc_pkg::ptr_inc(uw_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    got = '0;
    if (ok_r) begin
      priority if (tpfc_pkg::op_e_t'(op_r) == tpfc_pkg::OP_MASTER_POP) begin
        got = up_rdata;
      end else if (tpfc_pkg::op_e_t'(op_r) == tpfc_pkg::OP_SLAVE_POP) begin
        got = down_rdata;
      end else begin
        got = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpfc_pkg::S_IDLE;
      dw_r        <= '0;
      dr_r        <= '0;
      uw_r        <= '0;
      ur_r        <= '0;
      crlf_r      <= 1'b1;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dw_r    <= dw_nxt;
      dr_r    <= dr_nxt;
      uw_r    <= uw_nxt;
      ur_r    <= ur_nxt;
      ok_r    <= ok_nxt;
      if (cfg_wr_en) begin
        crlf_r <= cfg_wr_data;
      end
      if (state_r == tpfc_pkg::S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      byte_r <= in_byte_in;
    end
    if (state_r == tpfc_pkg::S_RESP && out_free) begin
      out_accepted_r <= ok_r;
      out_byte_r     <= got;
      out_mr_r       <= (uw_r != ur_r);
      out_mw_r       <= down_has_slot;
      out_sr_r       <= (dw_r != dr_r);
      out_sw_r       <= up_has_slot;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_accepted_r;
  assign out_byte_out        = out_byte_r;
  assign out_master_readable = out_mr_r;
  assign out_master_writable = out_mw_r;
  assign out_slave_readable  = out_sr_r;
  assign out_slave_writable  = out_sw_r;

  `TPFC_ASSERT_NEXT(a_down_no_overrun, clk, rst_n, down_we, dw_r != dr_r)
  `TPFC_ASSERT_NEXT(a_up_no_overrun, clk, rst_n, up_we, uw_r != ur_r)
  `TPFC_ASSERT_NEXT(a_result_loaded, clk, rst_n,
                    state_r == tpfc_pkg::S_RESP && out_free, out_valid_r)
  `TPFC_ASSERT_IMPLY(a_one_ring_write, clk, rst_n, down_we, !up_we && !up_re && !down_re)

endmodule
